/* sv/dsec_pkg.sv */
// Shared types and constants for the DER signature encoding checker.
package dsec_pkg;

  localparam logic [7:0] SEQ_TAG   = 8'h30;
  localparam logic [7:0] INT_TAG   = 8'h02;
  localparam logic [6:0] MIN_LEN   = 7'd9;
  localparam logic [6:0] COUNT_MAX = 7'd127;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SHORT      = 4'd1,
    ST_LONG       = 4'd2,
    ST_SEQ_TAG    = 4'd3,
    ST_MARKER     = 4'd4,
    ST_S_MISPLACE = 4'd5,
    ST_MISMATCH   = 4'd6,
    ST_R_TAG      = 4'd7,
    ST_R_EMPTY    = 4'd8,
    ST_R_PADDED   = 4'd9,
    ST_S_TAG      = 4'd10,
    ST_S_EMPTY    = 4'd11,
    ST_S_PADDED   = 4'd12
  } status_e;

  typedef struct packed {
    logic [6:0] byte_count;
    logic       seq_tag_bad;
    logic [7:0] length_marker;
    logic       r_tag_bad;
    logic [7:0] r_len_seen;
    logic       r_first_zero;
    logic       r_second_high;
    logic       s_tag_bad;
    logic [7:0] s_len_seen;
    logic       s_first_zero;
    logic       s_second_high;
  } sig_state_t;

endpackage

/* sv/dsec_track.sv */
// Per-signature field capture: records tags, lengths and padding bits as bytes pass.
module dsec_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output dsec_pkg::sig_state_t view_o
);
  import dsec_pkg::*;

  sig_state_t state_q, state_d, view;
  logic [6:0] pos;
  logic [8:0] rpos;

  always_comb begin
    pos  = state_q.byte_count;
    rpos = {1'b0, state_q.r_len_seen};
    view = state_q;
    if (pos == 7'd0) view.seq_tag_bad   = (byte_i != SEQ_TAG);
    if (pos == 7'd1) view.length_marker = byte_i;
    if (pos == 7'd2) view.r_tag_bad     = (byte_i != INT_TAG);
    if (pos == 7'd3) view.r_len_seen    = byte_i;
    if (pos == 7'd4) view.r_first_zero  = (byte_i == 8'h00);
    if (pos == 7'd5) view.r_second_high = byte_i[7];
    // S header position follows the R length already captured
    if (pos > 7'd3) begin
      if ({2'b00, pos} == rpos + 9'd4) view.s_tag_bad     = (byte_i != INT_TAG);
      if ({2'b00, pos} == rpos + 9'd5) view.s_len_seen    = byte_i;
      if ({2'b00, pos} == rpos + 9'd6) view.s_first_zero  = (byte_i == 8'h00);
      if ({2'b00, pos} == rpos + 9'd7) view.s_second_high = byte_i[7];
    end
    view.byte_count = (pos < COUNT_MAX) ? pos + 7'd1 : COUNT_MAX;

    state_d = state_q;
    if (take_i) state_d = last_i ? '0 : view;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign view_o = view;

endmodule

/* sv/dsec_verdict.sv */
// Verdict logic: first failing check in priority order, or OK.
module dsec_verdict #(
  parameter int MAX_LENGTH = 73
) (
  input  dsec_pkg::sig_state_t view_i,
  output dsec_pkg::status_e    status_o
);
  import dsec_pkg::*;

  logic [6:0] size;
  logic [7:0] size_m3;
  logic [8:0] s_start;
  logic [9:0] total;
  logic       r_pad, s_pad;

  always_comb begin
    size    = view_i.byte_count;
    size_m3 = {1'b0, size} - 8'd3;
    s_start = {1'b0, view_i.r_len_seen} + 9'd5;
    total   = {2'b00, view_i.r_len_seen} + {2'b00, view_i.s_len_seen} + 10'd7;
    r_pad   = (view_i.r_len_seen > 8'd1) && view_i.r_first_zero && !view_i.r_second_high;
    s_pad   = (view_i.s_len_seen > 8'd1) && view_i.s_first_zero && !view_i.s_second_high;

    if (size < MIN_LEN)                          status_o = ST_SHORT;
    else if (size > 7'(MAX_LENGTH))              status_o = ST_LONG;
    else if (view_i.seq_tag_bad)                 status_o = ST_SEQ_TAG;
    else if (view_i.length_marker != size_m3)    status_o = ST_MARKER;
    else if (s_start >= {2'b00, size})           status_o = ST_S_MISPLACE;
    else if (total != {3'b000, size})            status_o = ST_MISMATCH;
    else if (view_i.r_tag_bad)                   status_o = ST_R_TAG;
    else if (view_i.r_len_seen == 8'd0)          status_o = ST_R_EMPTY;
    else if (r_pad)                              status_o = ST_R_PADDED;
    else if (view_i.s_tag_bad)                   status_o = ST_S_TAG;
    else if (view_i.s_len_seen == 8'd0)          status_o = ST_S_EMPTY;
    else if (s_pad)                              status_o = ST_S_PADDED;
    else                                         status_o = ST_OK;
  end

endmodule

/* sv/der_signature_encoding_check.sv */
// Top level: strict DER signature encoding checker with stream ports.
//
// Input stream: one signature byte per word on s_axis_tdata_i, s_axis_tlast_i
// high on the hash type byte that ends the signature.
// Output stream: one verdict word per signature, produced for the last byte.
// Status 0 means OK; then r_length and s_length carry the declared integer
// lengths, otherwise they read zero. hash_type is always the final byte.
// Throughput: one byte per cycle while s_axis_tready_o stays high. Each byte
// is held in an input register; the field capture and verdict logic then work
// on it from that register and load the result register once the last byte
// of a signature is taken from it.
// Reset clears the capture state and both register stages; no word is
// pending afterwards.
// When the receiver stalls, the verdict waits in the result register while
// bytes of the next signature keep flowing in; only a second final byte
// waits in the input register, which then deasserts s_axis_tready_o.
module der_signature_encoding_check #(
  parameter int MAX_LENGTH = 73
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] sig_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [3:0] status, [11:4] r_length,
                                        // [19:12] s_length, [27:20] hash_type
);
  import dsec_pkg::*;

  logic       in_valid_q, in_last_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic [27:0] out_data_q;
  logic       out_free, take, accept;
  sig_state_t view;
  status_e    status;
  logic [7:0] r_len_res, s_len_res;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign take     = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || take;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  dsec_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .view_o (view)
  );

  dsec_verdict #(.MAX_LENGTH(MAX_LENGTH)) u_verdict (
    .view_i   (view),
    .status_o (status)
  );

  assign r_len_res = (status == ST_OK) ? view.r_len_seen : 8'd0;
  assign s_len_res = (status == ST_OK) ? view.s_len_seen : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_last_q) begin
      out_data_q <= {in_byte_q, s_len_res, r_len_res, status};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_data_q};

`ifndef SYNTH
  // an OK verdict implies nonzero lengths that fit the size limits
  a_ok_lengths: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[3:0] == ST_OK) |->
      (out_data_q[11:4] != 8'd0 && out_data_q[19:12] != 8'd0 &&
       ({2'b00, out_data_q[11:4]} + {2'b00, out_data_q[19:12]} + 10'd7)
         <= 10'(MAX_LENGTH)))
    else $error("OK verdict with impossible lengths");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[3:0] != ST_OK) |->
      (out_data_q[19:4] == 16'd0))
    else $error("failing verdict carries lengths");

  a_load_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(take && in_last_q))
    else $error("verdict loaded without a final byte");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && in_last_q && out_valid_q))
    else $error("input stalled without a pending verdict");
`endif

endmodule

/* tb/verdict_board_pkg.sv */
// Scoreboard for the signature checker testbench: verdict prediction and word compare.
package verdict_board_pkg;
  import dsec_pkg::*;

  typedef struct {
    status_e    status;
    logic [7:0] r_len;
    logic [7:0] s_len;
    logic [7:0] hash;
  } verdict_t;

  class verdict_board;
    sig_state_t trk;
    verdict_t   pending_verdicts[$];
    int         max_len;
    int         errors;

    function new(int max_length);
      max_len = max_length;
      trk     = '0;
      errors  = 0;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    // Track one accepted byte; on the final byte queue the expected verdict.
    function void note_byte(logic [7:0] b, logic last);
      int       pos;
      int       r;
      int       s;
      int       size;
      status_e  v;
      verdict_t e;
      pos = trk.byte_count;
      r   = trk.r_len_seen;
      if (pos == 0) trk.seq_tag_bad = (b != SEQ_TAG);
      if (pos == 1) trk.length_marker = b;
      if (pos == 2) trk.r_tag_bad = (b != INT_TAG);
      if (pos == 3) trk.r_len_seen = b;
      if (pos == 4) trk.r_first_zero = (b == 8'h00);
      if (pos == 5) trk.r_second_high = b[7];
      // S fields sit behind R, positions relative to the R length seen so far
      if (pos > 3) begin
        if (pos == 4 + r) trk.s_tag_bad = (b != INT_TAG);
        if (pos == 5 + r) trk.s_len_seen = b;
        if (pos == 6 + r) trk.s_first_zero = (b == 8'h00);
        if (pos == 7 + r) trk.s_second_high = b[7];
      end
      if (trk.byte_count < COUNT_MAX) trk.byte_count = trk.byte_count + 7'd1;
      if (!last) return;

      size = trk.byte_count;
      r    = trk.r_len_seen;
      s    = trk.s_len_seen;
      if (size < int'(MIN_LEN)) v = ST_SHORT;
      else if (size > max_len) v = ST_LONG;
      else if (trk.seq_tag_bad) v = ST_SEQ_TAG;
      else if (int'(trk.length_marker) != size - 3) v = ST_MARKER;
      else if (5 + r >= size) v = ST_S_MISPLACE;
      else if (r + s + 7 != size) v = ST_MISMATCH;
      else if (trk.r_tag_bad) v = ST_R_TAG;
      else if (r == 0) v = ST_R_EMPTY;
      else if (r > 1 && trk.r_first_zero && !trk.r_second_high) v = ST_R_PADDED;
      else if (trk.s_tag_bad) v = ST_S_TAG;
      else if (s == 0) v = ST_S_EMPTY;
      else if (s > 1 && trk.s_first_zero && !trk.s_second_high) v = ST_S_PADDED;
      else v = ST_OK;

      e.status = v;
      e.r_len  = (v == ST_OK) ? trk.r_len_seen : 8'h00;
      e.s_len  = (v == ST_OK) ? trk.s_len_seen : 8'h00;
      e.hash   = b;
      pending_verdicts.insert(pending_verdicts.size(), e);
      trk = '0;
    endfunction

    function void check_verdict(logic [31:0] d);
      verdict_t e;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict word with none expected, expected none actual %h", $time, d);
        errors++;
        return;
      end
      e = pending_verdicts.pop_front();
      if (d[3:0] !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, d[3:0]);
        errors++;
      end
      if (d[11:4] !== e.r_len) begin
        $display("%0t: r_length expected %0d actual %0d", $time, e.r_len, d[11:4]);
        errors++;
      end
      if (d[19:12] !== e.s_len) begin
        $display("%0t: s_length expected %0d actual %0d", $time, e.s_len, d[19:12]);
        errors++;
      end
      if (d[27:20] !== e.hash) begin
        $display("%0t: hash_type expected %h actual %h", $time, e.hash, d[27:20]);
        errors++;
      end
    endfunction
  endclass

endpackage

/* tb/tb.sv */
// Testbench top: streams directed and random signatures through the DER checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsec_pkg::*;
  import verdict_board_pkg::*;

  localparam int MAX_LEN = 73;
  localparam int LIMIT   = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_data;

  verdict_board board;
  logic [7:0]   sig_bytes[$];
  bit           no_gaps;
  int           sent_bytes;
  int           sig_count;
  int           cycles;

  der_signature_encoding_check #(.MAX_LENGTH(MAX_LEN)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tlast_i  (in_last),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random backpressure, sampled at the rising edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready <= no_gaps || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) board.check_verdict(out_data);
  end

  function automatic void put_byte(logic [7:0] b);
    sig_bytes.insert(sig_bytes.size(), b);
  endfunction

  // Integer body: first byte often zero, second byte often with bit 7 clear.
  task automatic push_int(int n);
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom);
      if (k == 0 && $urandom_range(1)) b = 8'h00;
      if (k == 1 && $urandom_range(1)) b = 8'($urandom_range(127));
      put_byte(b);
    end
  endtask

  task automatic make_sig(int rl, int sl);
    sig_bytes.delete();
    put_byte(SEQ_TAG);
    put_byte(8'(rl + sl + 4));
    put_byte(INT_TAG);
    put_byte(8'(rl));
    push_int(rl);
    put_byte(INT_TAG);
    put_byte(8'(sl));
    push_int(sl);
    put_byte(8'($urandom));
  endtask

  task automatic make_noise(int n);
    sig_bytes.delete();
    repeat (n) put_byte(8'($urandom));
  endtask

  // Called at a falling edge; returns at a falling edge.
  task automatic send_sig();
    int n;
    n = sig_bytes.size();
    for (int i = 0; i < n; i++) begin
      while (!no_gaps && $urandom_range(99) < 38) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
      in_valid <= 1'b1;
      in_data  <= sig_bytes[i];
      in_last  <= (i == n - 1);
      do @(posedge clk_i); while (!in_ready);
      board.note_byte(sig_bytes[i], i == n - 1);
      @(negedge clk_i);
    end
    sent_bytes += n;
    sig_count++;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 80) return $urandom_range(6, 1);
    return $urandom_range(33, 7);
  endfunction

  initial begin
    int kind;
    int n;
    int idx;
    int rand_sigs;
    board      = new(MAX_LEN);
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = 8'h00;
    in_last    = 1'b0;
    no_gaps    = 1'b0;
    sent_bytes = 0;
    sig_count  = 0;
    cycles     = 0;
    rand_sigs  = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // no idling on either side through the first directed signatures
    no_gaps = 1'b1;
    // directed: shortest and longest legal forms
    make_sig(1, 1);   send_sig();
    make_sig(33, 33); send_sig();
    // one past the maximum length
    make_sig(33, 34); send_sig();
    // far past the counter saturation
    make_noise(140);  send_sig();
    no_gaps = 1'b0;
    // too short: single byte, then one byte under the minimum
    sig_bytes.delete(); put_byte(SEQ_TAG); send_sig();
    make_sig(1, 1); void'(sig_bytes.pop_back()); send_sig();
    // bad sequence tag, all ones and all zeros
    make_sig(2, 2); sig_bytes[0] = 8'h31; send_sig();
    sig_bytes.delete(); repeat (9) put_byte(8'hff); send_sig();
    sig_bytes.delete(); repeat (9) put_byte(8'h00); send_sig();
    // wrong length marker
    make_sig(2, 2); sig_bytes[1] = sig_bytes[1] + 8'd1; send_sig();
    // S length position beyond the end
    make_sig(3, 3); sig_bytes[3] = 8'd8; send_sig();
    make_sig(3, 3); sig_bytes[3] = 8'hff; send_sig();
    // lengths that do not add up
    make_sig(3, 3); sig_bytes[3] = 8'd2; sig_bytes[7] = 8'h10; send_sig();
    // R faults
    make_sig(3, 3); sig_bytes[2] = 8'h03; send_sig();
    make_sig(0, 4); send_sig();
    make_sig(3, 2); sig_bytes[4] = 8'h00; sig_bytes[5] = 8'h7f; send_sig();
    // leading zero allowed when the next byte has its top bit set, or length one
    make_sig(3, 2); sig_bytes[4] = 8'h00; sig_bytes[5] = 8'h80; send_sig();
    make_sig(1, 2); sig_bytes[4] = 8'h00; send_sig();
    // S faults, then a leading zero that is allowed before a set top bit
    make_sig(2, 3); sig_bytes[6] = 8'h05; send_sig();
    make_sig(3, 0); send_sig();
    make_sig(2, 3); sig_bytes[8] = 8'h00; sig_bytes[9] = 8'h01; send_sig();
    make_sig(2, 3); sig_bytes[8] = 8'h00; sig_bytes[9] = 8'hc0; send_sig();

    // random: well-formed signatures, some corrupted, truncated or extended, and noise
    while (sent_bytes < 520 || rand_sigs < 4) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        make_sig(pick_len(), pick_len());
        if ($urandom_range(99) < 30) begin
          idx = $urandom_range(sig_bytes.size() - 1);
          if ($urandom_range(1)) sig_bytes[idx] = 8'($urandom);
          else sig_bytes[idx] = sig_bytes[idx] ^ 8'(1 << $urandom_range(7));
        end
      end else if (kind < 85) begin
        make_sig(pick_len(), pick_len());
        n = $urandom_range(4, 1);
        if ($urandom_range(1)) begin
          repeat (n) if (sig_bytes.size() > 1) void'(sig_bytes.pop_back());
        end else begin
          repeat (n) put_byte(8'($urandom));
        end
      end else begin
        n = ($urandom_range(19) == 0) ? $urandom_range(140, 74) : $urandom_range(20, 1);
        make_noise(n);
        if ($urandom_range(1)) sig_bytes[0] = SEQ_TAG;
      end
      send_sig();
      rand_sigs++;
    end
    no_gaps  = 1'b0;
    in_valid <= 1'b0;
    in_last  <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
